FILE: sv/sorted_key_table_with_cursor_core_defines.svh
// Assertion macros used by the table core RTL.
`ifndef SORTED_KEY_TABLE_WITH_CURSOR_CORE_DEFINES_SVH
`define SORTED_KEY_TABLE_WITH_CURSOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define SKT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("skt check failed");

`define SKT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skt check failed");

`else

`define SKT_ASSERT(label, clk, rst_n, prop)

`define SKT_ASSERT_IMP(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/skt_pkg.sv
package skt_pkg;

    localparam int CAPACITY   = 1024;
    localparam int SAVE_DEPTH = 32;
    localparam int KEY_WIDTH  = 32;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int IDX_W  = $clog2(CAPACITY + 1);
    localparam int SD_W   = $clog2(SAVE_DEPTH + 1);
    localparam int SP_W   = (SAVE_DEPTH > 1) ? $clog2(SAVE_DEPTH) : 1;

    localparam logic [IDX_W-1:0] NONE_IDX = IDX_W'(CAPACITY);

    localparam logic [3:0] CMD_APPEND  = 4'd0;
    localparam logic [3:0] CMD_INSERT  = 4'd1;
    localparam logic [3:0] CMD_FIND    = 4'd2;
    localparam logic [3:0] CMD_REMOVE  = 4'd3;
    localparam logic [3:0] CMD_GET_AT  = 4'd4;
    localparam logic [3:0] CMD_FIRST   = 4'd5;
    localparam logic [3:0] CMD_LAST    = 4'd6;
    localparam logic [3:0] CMD_NEXT    = 4'd7;
    localparam logic [3:0] CMD_PREV    = 4'd8;
    localparam logic [3:0] CMD_CURRENT = 4'd9;
    localparam logic [3:0] CMD_PUSH    = 4'd10;
    localparam logic [3:0] CMD_POP     = 4'd11;
    localparam logic [3:0] CMD_CLEAR   = 4'd12;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NONE        = 3'd1;
    localparam logic [2:0] ST_FULL        = 3'd2;
    localparam logic [2:0] ST_STACK_FULL  = 3'd3;
    localparam logic [2:0] ST_STACK_EMPTY = 3'd4;

endpackage

FILE: sv/skt_ram.sv
module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wa,
    input  logic [WIDTH-1:0]         i_wd,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_ra,
    output logic [WIDTH-1:0]         o_rd
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

FILE: sv/sorted_key_table_with_cursor_core.sv
// Channel   Direction  Handshake           Payload
// command   in         i_valid / o_ready   i_cmd, i_key, i_position
// result    out        o_valid / i_ready   o_status, o_found_key, o_cursor_index,
//                                          o_last_insert_index, o_entry_count
// config    in         i_cfg_wr_en         i_cfg_wr_data (sorted_mode)
// One transaction at a time; o_ready is high only while the sequencer is idle.
// Cursor and stack commands go straight to fetch and done; find and remove bisect in
// sorted mode, a read then a compare state per step, or else scan; insert and remove
// then shift 1 key a cycle through the single-port-pair key RAM.
// Synchronous active-low reset empties the table; RAM contents are not cleared.
// A result waiting on i_ready holds the sequencer in its final state.
`include "sorted_key_table_with_cursor_core_defines.svh"

module sorted_key_table_with_cursor_core
    import skt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_cmd,
    input  logic [31:0] i_key,
    input  logic [9:0]  i_position,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_found_key,
    output logic [10:0] o_cursor_index,
    output logic [10:0] o_last_insert_index,
    output logic [10:0] o_entry_count
);

    typedef enum logic [3:0] {
        S_IDLE, S_BS_RD, S_BS_CMP, S_CHK_RD, S_CHK_CMP, S_SCAN,
        S_SHUP, S_WRKEY, S_SHDN, S_FETCH, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [3:0]           r_cmd, n_cmd;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic                 r_mode, n_mode;
    logic [IDX_W-1:0]     r_lo, n_lo, r_hi, n_hi, r_idx, n_idx, r_p, n_p, r_cmp, n_cmp;
    logic                 r_pend, n_pend;
    logic [ADDR_W-1:0]    r_wa, n_wa;
    logic [2:0]           r_st, n_st;
    logic                 r_fk_rd, n_fk_rd;
    logic [IDX_W-1:0]     r_count, n_count, r_cursor, n_cursor, r_last, n_last;
    logic [IDX_W-1:0]     r_sav [SAVE_DEPTH];
    logic [IDX_W-1:0]     n_sav [SAVE_DEPTH];
    logic [SD_W-1:0]      r_depth, n_depth;
    logic                 r_o_valid, n_o_valid;
    logic [2:0]           r_o_status, n_o_status;
    logic [31:0]          r_o_fk, n_o_fk;
    logic [IDX_W-1:0]     r_o_cur, n_o_cur, r_o_last, n_o_last, r_o_cnt, n_o_cnt;

    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_wa, ram_ra;
    logic [KEY_WIDTH-1:0] ram_wd, ram_rd;
    logic [IDX_W:0]       mid_sum;
    logic [IDX_W-1:0]     mid, tgt;
    logic                 go_right;

    skt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_keys (
        .i_clk (i_clk),
        .i_we  (ram_we),
        .i_wa  (ram_wa),
        .i_wd  (ram_wd),
        .i_re  (ram_re),
        .i_ra  (ram_ra),
        .o_rd  (ram_rd)
    );

    function automatic logic [IDX_W-1:0] grow(logic [IDX_W-1:0] v, logic [IDX_W-1:0] p);
        return (v != NONE_IDX && v >= p) ? v + IDX_W'(1) : v;
    endfunction

    function automatic logic [IDX_W-1:0] shrink(logic [IDX_W-1:0] v, logic [IDX_W-1:0] p);
        if (v == NONE_IDX || v < p) return v;
        return (v == '0) ? NONE_IDX : v - IDX_W'(1);
    endfunction

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[IDX_W:1];
    assign go_right = (r_cmd == CMD_APPEND) ? (ram_rd <= r_key) : (ram_rd < r_key);

    always_comb begin
        n_state = r_state;  n_cmd = r_cmd;    n_key = r_key;     n_mode = r_mode;
        n_lo = r_lo;        n_hi = r_hi;      n_idx = r_idx;     n_p = r_p;
        n_cmp = r_cmp;      n_pend = r_pend;  n_wa = r_wa;       n_st = r_st;
        n_fk_rd = r_fk_rd;  n_count = r_count; n_cursor = r_cursor;
        n_last = r_last;    n_sav = r_sav;    n_depth = r_depth;
        n_o_status = r_o_status; n_o_fk = r_o_fk;
        n_o_cur = r_o_cur;  n_o_last = r_o_last; n_o_cnt = r_o_cnt;
        n_o_valid = r_o_valid && !i_ready;
        tgt = '0;
        ram_we = 1'b0; ram_wa = r_wa; ram_wd = ram_rd;
        ram_re = 1'b0; ram_ra = '0;
        if (i_cfg_wr_en) begin
            n_mode = i_cfg_wr_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_key   = i_key[KEY_WIDTH-1:0];
                    n_st    = ST_OK;
                    n_state = S_FETCH;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    case (i_cmd) inside
                        CMD_APPEND, CMD_INSERT: begin
                            if (r_count == NONE_IDX) begin
                                n_st = ST_FULL;
                            end else if (r_mode) begin
                                n_state = S_BS_RD;
                            end else begin
                                n_p     = (i_cmd == CMD_INSERT) ? '0 : r_count;
                                n_idx   = r_count;
                                n_state = S_SHUP;
                            end
                        end
                        CMD_FIND, CMD_REMOVE: begin
                            n_state = r_mode ? S_BS_RD : S_SCAN;
                        end
                        CMD_GET_AT, CMD_FIRST, CMD_LAST, CMD_NEXT: begin
                            case (i_cmd)
                                CMD_GET_AT: tgt = IDX_W'(i_position);
                                CMD_FIRST:  tgt = '0;
                                CMD_LAST:   tgt = r_count - IDX_W'(1);
                                default:    tgt = (r_cursor == NONE_IDX) ? '0
                                                  : r_cursor + IDX_W'(1);
                            endcase
                            if (r_count != '0 && tgt < r_count) begin
                                n_cursor = tgt;
                            end else begin
                                n_st = ST_NONE;
                            end
                        end
                        CMD_PREV: begin
                            if (r_count == '0 || r_cursor == '0 || r_cursor == NONE_IDX
                                || r_cursor - IDX_W'(1) >= r_count) begin
                                n_st = ST_NONE;
                            end else begin
                                n_cursor = r_cursor - IDX_W'(1);
                            end
                        end
                        CMD_CURRENT: begin
                            n_st = (r_cursor < r_count) ? ST_OK : ST_NONE;
                        end
                        CMD_PUSH: begin
                            if (r_depth >= SD_W'(SAVE_DEPTH)) begin
                                n_st = ST_STACK_FULL;
                            end else begin
                                n_sav[r_depth[SP_W-1:0]] = r_cursor;
                                n_depth = r_depth + SD_W'(1);
                            end
                        end
                        CMD_POP: begin
                            if (r_depth == '0) begin
                                n_st = ST_STACK_EMPTY;
                            end else begin
                                n_depth  = r_depth - SD_W'(1);
                                n_cursor = r_sav[n_depth[SP_W-1:0]];
                                n_st = (n_cursor < r_count) ? ST_OK : ST_NONE;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count  = '0;
                            n_cursor = NONE_IDX;
                            n_last   = NONE_IDX;
                            n_depth  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_BS_RD: begin
                if (r_lo < r_hi) begin
                    ram_re  = 1'b1;
                    ram_ra  = mid[ADDR_W-1:0];
                    n_idx   = mid;
                    n_state = S_BS_CMP;
                end else begin
                    n_p = r_lo;
                    if (r_cmd == CMD_APPEND || r_cmd == CMD_INSERT) begin
                        n_idx   = r_count;
                        n_state = S_SHUP;
                    end else begin
                        n_state = S_CHK_RD;
                    end
                end
            end
            S_BS_CMP: begin
                if (go_right) begin
                    n_lo = r_idx + IDX_W'(1);
                end else begin
                    n_hi = r_idx;
                end
                n_state = S_BS_RD;
            end
            S_CHK_RD: begin
                if (r_p < r_count) begin
                    ram_re  = 1'b1;
                    ram_ra  = r_p[ADDR_W-1:0];
                    n_state = S_CHK_CMP;
                end else begin
                    n_st    = ST_NONE;
                    n_state = S_FETCH;
                    if (r_cmd == CMD_FIND) n_cursor = NONE_IDX;
                end
            end
            S_CHK_CMP, S_SCAN: begin
                if ((r_state == S_CHK_CMP || r_pend) && ram_rd == r_key) begin
                    tgt    = (r_state == S_CHK_CMP) ? r_p : r_cmp;
                    n_p    = tgt;
                    n_pend = 1'b0;
                    if (r_cmd == CMD_FIND) begin
                        n_cursor = tgt;
                        n_state  = S_FETCH;
                    end else begin
                        n_idx   = tgt + IDX_W'(1);
                        n_state = S_SHDN;
                    end
                end else if (r_state == S_SCAN && r_idx < r_count) begin
                    ram_re = 1'b1;
                    ram_ra = r_idx[ADDR_W-1:0];
                    n_pend = 1'b1;
                    n_cmp  = r_idx;
                    n_idx  = r_idx + IDX_W'(1);
                end else begin
                    n_st    = ST_NONE;
                    n_state = S_FETCH;
                    if (r_cmd == CMD_FIND) n_cursor = NONE_IDX;
                end
            end
            S_SHUP: begin
                ram_we = r_pend;
                if (r_idx > r_p) begin
                    ram_re = 1'b1;
                    ram_ra = ADDR_W'(r_idx - IDX_W'(1));
                    n_pend = 1'b1;
                    n_wa   = r_idx[ADDR_W-1:0];
                    n_idx  = r_idx - IDX_W'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_WRKEY;
                end
            end
            S_WRKEY: begin
                ram_we   = 1'b1;
                ram_wa   = r_p[ADDR_W-1:0];
                ram_wd   = r_key;
                n_count  = r_count + IDX_W'(1);
                n_last   = r_p;
                n_cursor = grow(r_cursor, r_p);
                for (int i = 0; i < SAVE_DEPTH; i++) n_sav[i] = grow(r_sav[i], r_p);
                n_state  = S_FETCH;
            end
            S_SHDN: begin
                ram_we = r_pend;
                if (r_idx < r_count) begin
                    ram_re = 1'b1;
                    ram_ra = r_idx[ADDR_W-1:0];
                    n_pend = 1'b1;
                    n_wa   = ADDR_W'(r_idx - IDX_W'(1));
                    n_idx  = r_idx + IDX_W'(1);
                end else begin
                    n_pend   = 1'b0;
                    n_count  = r_count - IDX_W'(1);
                    n_cursor = shrink(r_cursor, r_p);
                    if (r_last != NONE_IDX) begin
                        if (r_p < r_last) n_last = r_last - IDX_W'(1);
                        else if (r_p == r_last) n_last = NONE_IDX;
                    end
                    for (int i = 0; i < SAVE_DEPTH; i++) n_sav[i] = shrink(r_sav[i], r_p);
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_fk_rd = (r_st == ST_OK) && (r_cursor < r_count);
                ram_re  = 1'b1;
                ram_ra  = r_cursor[ADDR_W-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_st;
                    n_o_fk     = r_fk_rd ? 32'(ram_rd) : '0;
                    n_o_cur    = r_cursor;
                    n_o_last   = r_last;
                    n_o_cnt    = r_count;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;  r_key <= n_key;  r_lo <= n_lo;  r_hi <= n_hi;
        r_idx <= n_idx;  r_p <= n_p;      r_cmp <= n_cmp; r_wa <= n_wa;
        r_st <= n_st;    r_fk_rd <= n_fk_rd; r_sav <= n_sav;
        r_o_status <= n_o_status; r_o_fk <= n_o_fk;
        r_o_cur <= n_o_cur; r_o_last <= n_o_last; r_o_cnt <= n_o_cnt;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= 1'b1;
            r_pend    <= 1'b0;
            r_count   <= '0;
            r_cursor  <= NONE_IDX;
            r_last    <= NONE_IDX;
            r_depth   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_pend    <= n_pend;
            r_count   <= n_count;
            r_cursor  <= n_cursor;
            r_last    <= n_last;
            r_depth   <= n_depth;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_ready             = (r_state == S_IDLE);
    assign o_valid             = r_o_valid;
    assign o_status            = r_o_status;
    assign o_found_key         = r_o_fk;
    assign o_cursor_index      = r_o_cur;
    assign o_last_insert_index = r_o_last;
    assign o_entry_count       = r_o_cnt;

    `SKT_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= NONE_IDX)
    `SKT_ASSERT(a_depth_range, i_clk, i_rst_n, r_depth <= SD_W'(SAVE_DEPTH))
    `SKT_ASSERT(a_last_valid, i_clk, i_rst_n, r_last == NONE_IDX || r_last < r_count)
    `SKT_ASSERT_IMP(a_write_in_shift, i_clk, i_rst_n, ram_we,
        r_state == S_SHUP || r_state == S_SHDN || r_state == S_WRKEY)

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb
    import skt_pkg::*;
();

    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] key;
        logic [9:0]  position;
    } command_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_key;
        logic [10:0] cursor_index;
        logic [10:0] last_insert_index;
        logic [10:0] entry_count;
    } outcome_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_wr_data;
    logic        i_valid;
    logic        o_ready;
    logic [3:0]  i_cmd;
    logic [31:0] i_key;
    logic [9:0]  i_position;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [31:0] o_found_key;
    logic [10:0] o_cursor_index;
    logic [10:0] o_last_insert_index;
    logic [10:0] o_entry_count;

    sorted_key_table_with_cursor_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_cmd               (i_cmd),
        .i_key               (i_key),
        .i_position          (i_position),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_found_key         (o_found_key),
        .o_cursor_index      (o_cursor_index),
        .o_last_insert_index (o_last_insert_index),
        .o_entry_count       (o_entry_count)
    );

    // table model
    logic [31:0]      tbl_keys [CAPACITY];
    logic [10:0]      tbl_count;
    logic [10:0]      tbl_cursor;
    logic [10:0]      tbl_last;
    logic [10:0]      tbl_saved [SAVE_DEPTH];
    int               tbl_depth;
    logic             tbl_sorted;

    command_t         pending_cmds [$];
    outcome_t         expected_outcomes [$];
    int               error_count;
    int               drv_wait;
    int               mon_wait;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int find_bound(logic [31:0] k, bit after_equal);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = tbl_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (after_equal ? (tbl_keys[mid] <= k) : (tbl_keys[mid] < k)) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic logic [10:0] find_first(logic [31:0] k);
        int i;
        if (tbl_sorted) begin
            i = find_bound(k, 1'b0);
            return (i < tbl_count && tbl_keys[i] == k) ? 11'(i) : NONE_IDX;
        end
        for (i = 0; i < tbl_count; i++)
            if (tbl_keys[i] == k) return 11'(i);
        return NONE_IDX;
    endfunction

    function automatic logic [10:0] shift_up(logic [10:0] v, logic [10:0] p);
        return (v != NONE_IDX && v >= p) ? v + 11'd1 : v;
    endfunction

    function automatic logic [10:0] shift_down(logic [10:0] v, logic [10:0] p);
        if (v == NONE_IDX || v < p) return v;
        return (v == 0) ? NONE_IDX : v - 11'd1;
    endfunction

    function automatic logic [2:0] move_cursor(int n);
        if (n >= tbl_count) return ST_NONE;
        tbl_cursor = 11'(n);
        return ST_OK;
    endfunction

    function automatic outcome_t apply_command(command_t c);
        outcome_t    r;
        logic [2:0]  st;
        logic [10:0] p;
        int          i;
        st = ST_OK;
        case (c.cmd)
            CMD_APPEND, CMD_INSERT: begin
                if (tbl_count >= CAPACITY) st = ST_FULL;
                else begin
                    if (tbl_sorted) p = 11'(find_bound(c.key, c.cmd == CMD_APPEND));
                    else p = (c.cmd == CMD_INSERT) ? 11'd0 : tbl_count;
                    for (i = tbl_count; i > p; i--) tbl_keys[i] = tbl_keys[i-1];
                    tbl_keys[p] = c.key;
                    tbl_cursor = shift_up(tbl_cursor, p);
                    for (i = 0; i < tbl_depth; i++) tbl_saved[i] = shift_up(tbl_saved[i], p);
                    tbl_count++;
                    tbl_last = p;
                end
            end
            CMD_FIND: begin
                tbl_cursor = find_first(c.key);
                st = (tbl_cursor == NONE_IDX) ? ST_NONE : ST_OK;
            end
            CMD_REMOVE: begin
                p = find_first(c.key);
                if (p == NONE_IDX) st = ST_NONE;
                else begin
                    for (i = p; i + 1 < tbl_count; i++) tbl_keys[i] = tbl_keys[i+1];
                    tbl_count--;
                    tbl_cursor = shift_down(tbl_cursor, p);
                    if (tbl_last != NONE_IDX) begin
                        if (p < tbl_last) tbl_last--;
                        else if (p == tbl_last) tbl_last = NONE_IDX;
                    end
                    for (i = 0; i < tbl_depth; i++) tbl_saved[i] = shift_down(tbl_saved[i], p);
                end
            end
            CMD_GET_AT: st = move_cursor(c.position);
            CMD_FIRST: st = move_cursor(0);
            CMD_LAST: st = (tbl_count == 0) ? ST_NONE : move_cursor(tbl_count - 1);
            CMD_NEXT: begin
                if (tbl_count == 0) st = ST_NONE;
                else st = move_cursor(tbl_cursor == NONE_IDX ? 0 : tbl_cursor + 1);
            end
            CMD_PREV: begin
                if (tbl_count == 0 || tbl_cursor == 0 || tbl_cursor == NONE_IDX) st = ST_NONE;
                else st = move_cursor(tbl_cursor - 1);
            end
            CMD_CURRENT: st = (tbl_cursor < tbl_count) ? ST_OK : ST_NONE;
            CMD_PUSH: begin
                if (tbl_depth >= SAVE_DEPTH) st = ST_STACK_FULL;
                else begin
                    tbl_saved[tbl_depth] = tbl_cursor;
                    tbl_depth++;
                end
            end
            CMD_POP: begin
                if (tbl_depth == 0) st = ST_STACK_EMPTY;
                else begin
                    tbl_depth--;
                    tbl_cursor = tbl_saved[tbl_depth];
                    st = (tbl_cursor < tbl_count) ? ST_OK : ST_NONE;
                end
            end
            CMD_CLEAR: begin
                tbl_count = '0;
                tbl_cursor = NONE_IDX;
                tbl_last = NONE_IDX;
                tbl_depth = 0;
            end
            default: ;
        endcase
        r.status = st;
        r.found_key = (st == ST_OK && tbl_cursor < tbl_count) ? tbl_keys[tbl_cursor] : 32'd0;
        r.cursor_index = tbl_cursor;
        r.last_insert_index = tbl_last;
        r.entry_count = tbl_count;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            drv_wait <= $urandom_range(0, 15);
        end else if (i_valid && o_ready) begin
            expected_outcomes.push_back(apply_command(pending_cmds.pop_front()));
            drv_wait = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) drv_wait = 0;
            if (drv_wait == 0 && pending_cmds.size() > 0) begin
                {i_cmd, i_key, i_position} <= pending_cmds[0];
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid && pending_cmds.size() > 0) begin
            if (drv_wait > 0) drv_wait <= drv_wait - 1;
            else begin
                i_valid <= 1'b1;
                {i_cmd, i_key, i_position} <= pending_cmds[0];
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        outcome_t got;
        outcome_t exp_r;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            mon_wait = $urandom_range(0, 15);
        end else begin
            if (o_valid && i_ready) begin
                got = {o_status, o_found_key, o_cursor_index, o_last_insert_index,
                       o_entry_count};
                if (expected_outcomes.size() == 0) begin
                    $error("unexpected result transaction");
                    error_count++;
                end else begin
                    exp_r = expected_outcomes.pop_front();
                    if (got.status !== exp_r.status) begin
                        $error("status: expected %0d actual %0d", exp_r.status, got.status);
                        error_count++;
                    end
                    if (got.found_key !== exp_r.found_key) begin
                        $error("found_key: expected %h actual %h", exp_r.found_key,
                               got.found_key);
                        error_count++;
                    end
                    if (got.cursor_index !== exp_r.cursor_index) begin
                        $error("cursor_index: expected %0d actual %0d", exp_r.cursor_index,
                               got.cursor_index);
                        error_count++;
                    end
                    if (got.last_insert_index !== exp_r.last_insert_index) begin
                        $error("last_insert_index: expected %0d actual %0d",
                               exp_r.last_insert_index, got.last_insert_index);
                        error_count++;
                    end
                    if (got.entry_count !== exp_r.entry_count) begin
                        $error("entry_count: expected %0d actual %0d", exp_r.entry_count,
                               got.entry_count);
                        error_count++;
                    end
                end
                mon_wait = $urandom_range(0, 15);
                if ($urandom_range(0, 3) == 0) mon_wait = 0;
            end
            if (mon_wait > 0) begin
                mon_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] pick_key(logic [31:0] pool_lo);
        case ($urandom_range(0, 3))
            0: return $urandom;
            default: return pool_lo + $urandom_range(0, 7);
        endcase
    endfunction

    task automatic queue_cmd(logic [3:0] c, logic [31:0] k, logic [9:0] p);
        command_t x;
        x.cmd = c;
        x.key = k;
        x.position = p;
        pending_cmds.push_back(x);
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_outcomes.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
    endtask

    task automatic write_mode(logic m);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tbl_sorted = m;
    endtask

    task automatic random_phase(int n, logic [31:0] base);
        int   i;
        int   r;
        logic [3:0] c;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30) c = CMD_APPEND;
            else if (r < 45) c = CMD_INSERT;
            else if (r < 55) c = CMD_FIND;
            else if (r < 68) c = CMD_REMOVE;
            else if (r < 99) c = 4'($urandom_range(4, 11));
            else c = ($urandom_range(0, 3) == 0) ? CMD_CLEAR : 4'($urandom_range(13, 15));
            queue_cmd(c, pick_key(base), ($urandom_range(0, 1)) ? 10'($urandom)
                                                             : 10'($urandom_range(0, 40)));
        end
    endtask

    initial begin
        int i;
        error_count = 0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_cmd = '0;
        i_key = '0;
        i_position = '0;
        tbl_count = '0;
        tbl_cursor = NONE_IDX;
        tbl_last = NONE_IDX;
        tbl_depth = 0;
        tbl_sorted = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-table cases, extremes, every command
        queue_cmd(CMD_FIND, 32'd5, 10'd0);
        queue_cmd(CMD_REMOVE, 32'd5, 10'd0);
        queue_cmd(CMD_NEXT, 32'd0, 10'd0);
        queue_cmd(CMD_PREV, 32'd0, 10'd0);
        queue_cmd(CMD_LAST, 32'd0, 10'd0);
        queue_cmd(CMD_CURRENT, 32'd0, 10'd0);
        queue_cmd(CMD_POP, 32'd0, 10'd0);
        queue_cmd(CMD_PUSH, 32'd0, 10'd0);
        queue_cmd(CMD_APPEND, 32'hFFFF_FFFF, 10'h3FF);
        queue_cmd(CMD_INSERT, 32'd0, 10'd0);
        queue_cmd(CMD_APPEND, 32'd7, 10'd0);
        queue_cmd(CMD_INSERT, 32'd7, 10'd0);
        queue_cmd(CMD_GET_AT, 32'd0, 10'h3FF);
        queue_cmd(CMD_GET_AT, 32'd0, 10'd2);
        queue_cmd(CMD_POP, 32'd0, 10'd0);
        queue_cmd(CMD_FIRST, 32'd0, 10'd0);
        queue_cmd(CMD_PREV, 32'd0, 10'd0);
        queue_cmd(CMD_LAST, 32'd0, 10'd0);
        queue_cmd(CMD_NEXT, 32'd0, 10'd0);
        queue_cmd(CMD_PUSH, 32'd0, 10'd0);
        queue_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 10'd0);
        queue_cmd(CMD_POP, 32'd0, 10'd0);
        queue_cmd(CMD_FIND, 32'd7, 10'd0);
        queue_cmd(CMD_REMOVE, 32'd0, 10'd0);
        queue_cmd(4'd15, 32'hA5A5_5A5A, 10'h155);
        queue_cmd(CMD_CLEAR, 32'd0, 10'd0);
        drain();

        // stack full, then cursor shifts on saved entries
        for (i = 0; i < 34; i++) queue_cmd(CMD_PUSH, 32'd0, 10'd0);
        for (i = 0; i < 34; i++) queue_cmd(CMD_POP, 32'd0, 10'd0);
        random_phase(150, 32'd100);
        drain();

        write_mode(1'b0);
        random_phase(150, 32'd100);
        drain();

        // sorted commands over an arrival-ordered table
        write_mode(1'b1);
        random_phase(120, 32'hFFFF_FFF8);
        queue_cmd(CMD_CLEAR, 32'd0, 10'd0);
        drain();

        write_mode(1'b1);
        random_phase(60, 32'd0);
        drain();
        if (error_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #60ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
